FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue.
// Holds the command codes and the control struct that the queue sends to its cells.
// No dependencies.
package spq_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } spq_cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctl_t;

endpackage

FILE: rtl/spq_cell.sv
// One storage cell of the sorted queue chain: a key/value pair.
// On a push, the cell keeps its pair, takes the new pair, or takes its left neighbor's pair.
// On a pop, it takes its right neighbor's pair. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  spq_ctl_t              ctl,
  input  logic                  occupied,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  left_stay,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic                  stay,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic [KEY_BITS-1:0]   key_next
);

  logic [VALUE_BITS-1:0] value_next;

  // Cells that stay on a push form a prefix of the chain.
  assign stay = occupied && (key <= in_key);

  always_comb begin
    key_next   = key;
    value_next = value;
    if (ctl.push) begin
      if (!stay) begin
        if (left_stay) begin
          key_next   = in_key;
          value_next = in_value;
        end else begin
          key_next   = left_key;
          value_next = left_value;
        end
      end
    end else if (ctl.pop) begin
      key_next   = right_key;
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    value <= value_next;
  end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue of key/value pairs, built as a chain of shifting cells.
// Top level. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel s_*: one item per command. s_tuser is the command (0 push, 1 pop);
//   s_tdata carries the key and the payload. A push inserts after all entries with
//   a key less than or equal to its own, so equal keys leave in arrival order.
//   Output channel m_*: exactly one result item per command, in order. It carries
//   ok, the popped value (0 unless a pop found an entry), the smallest key after
//   the operation (all ones when empty), the entry count and a full flag.
//   A push when full, or a push of the all-ones key, is dropped with ok low.
//   Output: the result is registered, valid the cycle after the command is accepted.
//   Throughput: one command per cycle when not stalled; every cell compares against
//   the new key in parallel and shifts one place to a neighbor in the same cycle.
//   Receiver stall: the single output register holds its result and s_tready drops
//   until the result is taken; no item is lost.
//   Reset: the queue is empty and no result is pending; the cells need no clearing.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int CNT_BITS  = $clog2(CAPACITY + 1),
  localparam int IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 + VALUE_BITS + KEY_BITS + CNT_BITS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // key, payload, zero pad
  input  logic             s_tuser,  // cmd
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // ok, popped_value, min_key, entry_count, is_full, pad
);

  localparam logic [KEY_BITS-1:0] KEY_EMPTY = '1;
  localparam logic [CNT_BITS-1:0] CAP_CNT   = CNT_BITS'(CAPACITY);

  logic                  accept;
  spq_cmd_t              cmd;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  spq_ctl_t              ctl;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;

  logic [CAPACITY-1:0]   stay;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [KEY_BITS-1:0]   cell_key_next [CAPACITY];

  logic                  res_ok;
  logic [VALUE_BITS-1:0] res_value;
  logic [KEY_BITS-1:0]   res_min;
  logic [CNT_BITS-1:0]   res_count;
  logic                  res_full;
  logic [OUT_BITS-1:0]   res_vec;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = spq_cmd_t'(s_tuser);
  assign in_key   = s_tdata[KEY_BITS-1:0];
  assign in_value = s_tdata[KEY_BITS+VALUE_BITS-1 -: VALUE_BITS];

  assign ctl.push = accept && (cmd == CMD_PUSH) && (count != CAP_CNT) && (in_key != KEY_EMPTY);
  assign ctl.pop  = accept && (cmd == CMD_POP) && (count != '0);

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CNT_BITS'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_BITS'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_stay;
    logic [KEY_BITS-1:0]   l_key;
    logic [VALUE_BITS-1:0] l_value;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    if (i == 0) begin : g_head
      assign l_stay  = 1'b1;
      assign l_key   = in_key;
      assign l_value = in_value;
    end else begin : g_body
      assign l_stay  = stay[i-1];
      assign l_key   = cell_key[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = KEY_EMPTY;
      assign r_value = '0;
    end else begin : g_mid
      assign r_key   = cell_key[i+1];
      assign r_value = cell_value[i+1];
    end

    spq_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (count > CNT_BITS'(i)),
      .in_key      (in_key),
      .in_value    (in_value),
      .left_stay   (l_stay),
      .left_key    (l_key),
      .left_value  (l_value),
      .right_key   (r_key),
      .right_value (r_value),
      .stay        (stay[i]),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .key_next    (cell_key_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok    <= ctl.push || ctl.pop;
      res_value <= ctl.pop ? cell_value[0] : '0;
      res_min   <= (count_next != '0) ? cell_key_next[0] : KEY_EMPTY;
      res_count <= count_next;
      res_full  <= (count_next == CAP_CNT);
    end
  end

  assign res_vec = {res_full, res_count, res_min, res_value, res_ok};
  assign m_tdata = OUT_W'(res_vec);

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for sorted_priority_queue: directed and random push/pop items,
// predicted by a sorted-list tracker and checked field by field on every result.
// Depends on spq_pkg and sorted_priority_queue.
module tb_top
  import spq_pkg::*;
();

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam logic [31:0] KEY_EMPTY = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        is_full;
    logic [4:0]  entry_count;
    logic [31:0] min_key;
    logic [31:0] popped_value;
    logic        ok;
  } spq_result_t;

  class min_queue_tracker;
    logic [31:0] keys [DEPTH];
    logic [31:0] vals [DEPTH];
    int fill;
    spq_result_t pending_results[$];
    int mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_command(spq_cmd_t cmd, logic [31:0] key, logic [31:0] payload);
      spq_result_t r;
      int pos;
      int i;
      r = '0;
      if (cmd == CMD_PUSH) begin
        if (fill < DEPTH && key != KEY_EMPTY) begin
          pos = 0;
          while (pos < fill && keys[pos] <= key) pos++;
          for (i = fill; i > pos; i--) begin
            keys[i] = keys[i-1];
            vals[i] = vals[i-1];
          end
          keys[pos] = key;
          vals[pos] = payload;
          fill++;
          r.ok = 1'b1;
        end
      end else if (fill > 0) begin
        r.popped_value = vals[0];
        for (i = 1; i < fill; i++) begin
          keys[i-1] = keys[i];
          vals[i-1] = vals[i];
        end
        fill--;
        r.ok = 1'b1;
      end
      r.min_key     = (fill > 0) ? keys[0] : KEY_EMPTY;
      r.entry_count = fill[4:0];
      r.is_full     = (fill == DEPTH);
      pending_results.push_back(r);
    endfunction

    task check_result(spq_result_t got);
      spq_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok)
        report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
      if (got.popped_value !== want.popped_value)
        report_mismatch($sformatf("popped_value %h, expected %h",
                                  got.popped_value, want.popped_value));
      if (got.min_key !== want.min_key)
        report_mismatch($sformatf("min_key %h, expected %h", got.min_key, want.min_key));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                  got.entry_count, want.entry_count));
      if (got.is_full !== want.is_full)
        report_mismatch($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // key, payload
  logic        s_tuser = 1'b0;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;  // ok, popped_value, min_key, entry_count, is_full, pad

  min_queue_tracker tracker = new();
  bit long_hold = 1'b0;
  bit rx_quiet = 1'b0;
  int stuck_cycles = 0;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // acceptance monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready)
        tracker.note_command(spq_cmd_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
      if (m_tvalid && m_tready)
        tracker.check_result(spq_result_t'(m_tdata[70:0]));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // receiver: random stall bursts, a long hold on each request, none at the end
  initial begin
    wait (!rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_quiet || $urandom_range(0, 11) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_item(spq_cmd_t cmd, logic [31:0] key, logic [31:0] payload);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {payload, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item(int push_pct, int key_mode);
    spq_cmd_t cmd;
    logic [31:0] key;
    cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
    case (key_mode)
      0: key = $urandom();
      1: key = $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = 32'hFFFF_FFFE;
          2: key = 32'hFFFF_FFF0 + $urandom_range(0, 14);
          default: key = $urandom_range(0, 3);
        endcase
      end
    endcase
    if ($urandom_range(0, 39) == 0) key = KEY_EMPTY;
    send_item(cmd, key, $urandom());
  endtask

  initial begin
    int seg;
    int n;
    int push_pct;
    int key_mode;
    int gap_pct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, reserved key, fill with ties and extremes, overflow, pops
    send_item(CMD_POP, 32'h0, 32'h0);
    send_item(CMD_PUSH, KEY_EMPTY, 32'h1234_5678);
    send_item(CMD_PUSH, 32'd5, 32'h0000_0000);
    send_item(CMD_PUSH, 32'd5, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 32'd5, 32'hA5A5_A5A5);
    send_item(CMD_PUSH, 32'd0, 32'h5A5A_5A5A);
    send_item(CMD_PUSH, 32'hFFFF_FFFE, 32'h0000_0001);
    send_item(CMD_PUSH, 32'hFFFF_FFFE, 32'h8000_0000);
    for (n = 0; n < 10; n++) send_item(CMD_PUSH, $urandom_range(0, 9), $urandom());
    send_item(CMD_PUSH, 32'd1, 32'hDEAD_0001);
    send_item(CMD_PUSH, KEY_EMPTY, 32'hDEAD_0002);
    for (n = 0; n < 5; n++) send_item(CMD_POP, $urandom(), $urandom());

    for (seg = 0; seg < 23; seg++) begin
      case ($urandom_range(0, 4))
        0: push_pct = 15;
        1, 2: push_pct = 50;
        3: push_pct = 85;
        default: push_pct = 97;
      endcase
      key_mode = $urandom_range(0, 2);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if (seg == 6 || seg == 15) begin
        long_hold = 1'b1;
        push_pct = 97;
        gap_pct = 0;
      end
      if (seg == 12) drain();
      if (seg >= 19) begin
        gap_pct = 0;
        rx_quiet = 1'b1;
      end
      for (n = 0; n < 40; n++) begin
        random_item(push_pct, key_mode);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
          idle_gap($urandom_range(1, 17));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
